[rtl/core/sdi_pkg.sv]
package sdi_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWER,
    PH_GAP,
    PH_CMD,
    PH_POLL,
    PH_TAIL,
    PH_DONE
  } phase_e;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_APP_CMD   = 6'd55;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;
  localparam logic [5:0] CMD_CRC_ON    = 6'd59;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_IDLE        = 4'd1;
  localparam logic [3:0] ST_IF_COND     = 4'd2;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd3;
  localparam logic [3:0] ST_CRC_OFF     = 4'd4;
  localparam logic [3:0] ST_APP_CMD     = 4'd5;
  localparam logic [3:0] ST_OP_COND     = 4'd6;
  localparam logic [3:0] ST_OP_TIMEOUT  = 4'd7;
  localparam logic [3:0] ST_OCR         = 4'd8;
  localparam logic [3:0] ST_POWERUP     = 4'd9;
  localparam logic [3:0] ST_OCR_UNSUPP  = 4'd10;

  localparam logic [8:0] POWERUP_BYTES  = 9'd11;
  localparam logic [8:0] FRAME_BYTES    = 9'd6;
  localparam logic [7:0] IDLE_BYTE      = 8'hFF;
  localparam logic [7:0] R1_IDLE        = 8'h01;
  localparam logic [7:0] R1_ILLEGAL     = 8'h05;
  localparam logic [7:0] CHECK_PATTERN  = 8'hAA;
  localparam logic [7:0] VHS_27_36      = 8'h01;
  localparam logic [7:0] OCR_RSVD_MASK  = 8'h31;
  localparam logic [8:0] VOLT_WINDOW    = 9'h1FF;
  localparam logic [31:0] HCS_ARG       = 32'h4000_0000;

  function automatic logic [7:0] crc7_frame(logic [47:0] head);
    logic [47:0] rem;
    logic [47:0] poly;
    logic [47:0] probe;
    rem   = head;
    poly  = 48'h8900_0000_0000;
    probe = 48'h8000_0000_0000;
    for (int i = 0; i < 40; i++) begin
      if ((rem & probe) != 48'd0) begin
        rem = rem ^ poly;
      end
      poly  = poly >> 1;
      probe = probe >> 1;
    end
    return rem[7:0];
  endfunction

  function automatic logic [47:0] make_frame(logic [5:0] idx, logic [31:0] arg);
    logic [47:0] f;
    f = {2'b01, idx, arg, 8'h00};
    f[7:0] = crc7_frame(f) | 8'h01;
    return f;
  endfunction

  localparam logic [47:0] FRAME_CMD0      = make_frame(CMD_GO_IDLE, 32'd0);
  localparam logic [47:0] FRAME_CMD8      = make_frame(CMD_IF_COND, 32'h0000_01AA);
  localparam logic [47:0] FRAME_CMD55     = make_frame(CMD_APP_CMD, 32'd0);
  localparam logic [47:0] FRAME_ACMD41    = make_frame(CMD_OP_COND, 32'd0);
  localparam logic [47:0] FRAME_ACMD41_HC = make_frame(CMD_OP_COND, HCS_ARG);
  localparam logic [47:0] FRAME_CMD58     = make_frame(CMD_READ_OCR, 32'd0);
  localparam logic [47:0] FRAME_CMD59     = make_frame(CMD_CRC_ON, 32'd0);

  typedef struct packed {
    phase_e      phase;
    logic [8:0]  byte_cnt;
    logic [47:0] frame;
    logic [23:0] resp;
    logic [7:0]  retry;
    logic [1:0]  version;
    logic        capacity;
    logic [3:0]  status;
    logic [7:0]  r1;
    logic        timeout;
  } state_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_low;
    logic       done_res;
    logic [3:0] status;
    logic [7:0] last_response;
    logic       response_timeout;
    logic [1:0] card_version;
    logic       card_high_capacity;
  } result_t;

endpackage

[rtl/core/sdi_stream_if.sv]
interface sdi_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface sdi_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       select_low;
  logic       done_res;
  logic [3:0] status;
  logic [7:0] last_response;
  logic       response_timeout;
  logic [1:0] card_version;
  logic       card_high_capacity;

  modport source (
    output valid, output tx_valid, output tx_byte, output select_low, output done_res,
    output status, output last_response, output response_timeout, output card_version,
    output card_high_capacity, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input select_low, input done_res,
    input status, input last_response, input response_timeout, input card_version,
    input card_high_capacity, output ready
  );
endinterface

[rtl/core/sdi_step.sv]
module sdi_step #(
  parameter int POLL_LIMIT     = 256,
  parameter int OPCOND_RETRIES = 255,
  parameter int GAP_BYTES      = 10
) (
  input  sdi_pkg::state_t  state_i,
  input  logic             host_hc_i,
  input  logic             mode_i,
  input  logic [7:0]       rx_byte_i,
  output sdi_pkg::state_t  state_o,
  output sdi_pkg::result_t result_o
);

  localparam logic [8:0] GapLen   = 9'(GAP_BYTES);
  localparam logic [8:0] PollLen  = 9'(POLL_LIMIT);
  localparam logic [7:0] RetryMax = 8'(OPCOND_RETRIES - 1);

  always_comb begin
    sdi_pkg::state_t nxt;
    logic            start_cmd;
    logic [47:0]     start_frame;
    logic            fin;
    logic [3:0]      fin_code;
    logic            got_r1;
    logic [7:0]      r1v;
    logic [8:0]      cnt_inc;
    logic [23:0]     resp_new;
    logic [7:0]      ocr;
    logic [8:0]      win;

    nxt         = state_i;
    start_cmd   = 1'b0;
    start_frame = sdi_pkg::FRAME_CMD0;
    fin         = 1'b0;
    fin_code    = sdi_pkg::ST_OK;
    got_r1      = 1'b0;
    r1v         = rx_byte_i;
    cnt_inc     = state_i.byte_cnt + 9'd1;
    resp_new    = {state_i.resp[15:0], rx_byte_i};
    ocr         = resp_new[23:16];
    win         = {resp_new[15:8], resp_new[7]};

    if (!mode_i) begin
      nxt       = '0;
      nxt.phase = sdi_pkg::PH_POWER;
    end else begin
      unique case (state_i.phase)
        sdi_pkg::PH_POWER: begin
          nxt.byte_cnt = cnt_inc;
          if (cnt_inc >= sdi_pkg::POWERUP_BYTES) begin
            start_cmd   = 1'b1;
            start_frame = sdi_pkg::FRAME_CMD0;
          end
        end
        sdi_pkg::PH_GAP: begin
          nxt.byte_cnt = cnt_inc;
          if (cnt_inc >= GapLen) begin
            nxt.phase    = sdi_pkg::PH_CMD;
            nxt.byte_cnt = '0;
          end
        end
        sdi_pkg::PH_CMD: begin
          nxt.byte_cnt = cnt_inc;
          if (cnt_inc >= sdi_pkg::FRAME_BYTES) begin
            nxt.phase    = sdi_pkg::PH_POLL;
            nxt.byte_cnt = '0;
          end
        end
        sdi_pkg::PH_POLL: begin
          if (rx_byte_i != sdi_pkg::IDLE_BYTE) begin
            got_r1 = 1'b1;
            r1v    = rx_byte_i;
            nxt.r1 = rx_byte_i;
            nxt.timeout = 1'b0;
          end else begin
            nxt.byte_cnt = cnt_inc;
            if (cnt_inc >= PollLen) begin
              got_r1      = 1'b1;
              r1v         = sdi_pkg::IDLE_BYTE;
              nxt.r1      = sdi_pkg::IDLE_BYTE;
              nxt.timeout = 1'b1;
            end
          end
        end
        sdi_pkg::PH_TAIL: begin
          nxt.resp     = resp_new;
          nxt.byte_cnt = cnt_inc;
          if (state_i.frame[45:40] == sdi_pkg::CMD_IF_COND) begin
            if (cnt_inc >= 9'd4) begin
              if (state_i.r1 == sdi_pkg::R1_ILLEGAL) begin
                nxt.version = 2'd1;
                start_cmd   = 1'b1;
                start_frame = sdi_pkg::FRAME_CMD59;
              end else if (state_i.r1 == sdi_pkg::R1_IDLE) begin
                nxt.version = 2'd2;
                if (resp_new[15:8] != sdi_pkg::VHS_27_36 ||
                    resp_new[7:0] != sdi_pkg::CHECK_PATTERN) begin
                  fin      = 1'b1;
                  fin_code = sdi_pkg::ST_UNSUPPORTED;
                end else begin
                  start_cmd   = 1'b1;
                  start_frame = sdi_pkg::FRAME_CMD59;
                end
              end else begin
                fin      = 1'b1;
                fin_code = sdi_pkg::ST_IF_COND;
              end
            end
          end else if (cnt_inc == 9'd1) begin
            if (!rx_byte_i[7]) begin
              fin      = 1'b1;
              fin_code = sdi_pkg::ST_POWERUP;
            end
          end else if (cnt_inc >= 9'd3) begin
            nxt.capacity = ocr[6];
            fin          = 1'b1;
            if ((ocr & sdi_pkg::OCR_RSVD_MASK) != 8'd0 || win != sdi_pkg::VOLT_WINDOW) begin
              fin_code = sdi_pkg::ST_OCR_UNSUPP;
            end else begin
              fin_code = sdi_pkg::ST_OK;
            end
          end
        end
        default: begin
        end
      endcase

      if (got_r1) begin
        unique case (state_i.frame[45:40])
          sdi_pkg::CMD_GO_IDLE: begin
            if (r1v != sdi_pkg::R1_IDLE) begin
              fin      = 1'b1;
              fin_code = sdi_pkg::ST_IDLE;
            end else begin
              start_cmd   = 1'b1;
              start_frame = sdi_pkg::FRAME_CMD8;
            end
          end
          sdi_pkg::CMD_IF_COND, sdi_pkg::CMD_READ_OCR: begin
            if (state_i.frame[45:40] == sdi_pkg::CMD_READ_OCR && r1v != 8'd0) begin
              fin      = 1'b1;
              fin_code = sdi_pkg::ST_OCR;
            end else begin
              nxt.phase    = sdi_pkg::PH_TAIL;
              nxt.byte_cnt = '0;
              nxt.resp     = '0;
            end
          end
          sdi_pkg::CMD_CRC_ON: begin
            if (r1v != sdi_pkg::R1_IDLE) begin
              fin      = 1'b1;
              fin_code = sdi_pkg::ST_CRC_OFF;
            end else begin
              start_cmd   = 1'b1;
              start_frame = sdi_pkg::FRAME_CMD55;
            end
          end
          sdi_pkg::CMD_APP_CMD: begin
            if (r1v != sdi_pkg::R1_IDLE) begin
              fin      = 1'b1;
              fin_code = sdi_pkg::ST_APP_CMD;
            end else begin
              start_cmd   = 1'b1;
              start_frame = host_hc_i ? sdi_pkg::FRAME_ACMD41_HC : sdi_pkg::FRAME_ACMD41;
            end
          end
          default: begin
            if (r1v > sdi_pkg::R1_IDLE) begin
              fin      = 1'b1;
              fin_code = sdi_pkg::ST_OP_COND;
            end else if (r1v == sdi_pkg::R1_IDLE) begin
              if (state_i.retry >= RetryMax) begin
                fin      = 1'b1;
                fin_code = sdi_pkg::ST_OP_TIMEOUT;
              end else begin
                nxt.retry   = state_i.retry + 8'd1;
                start_cmd   = 1'b1;
                start_frame = sdi_pkg::FRAME_CMD55;
              end
            end else begin
              start_cmd   = 1'b1;
              start_frame = sdi_pkg::FRAME_CMD58;
            end
          end
        endcase
      end

      if (start_cmd) begin
        nxt.frame    = start_frame;
        nxt.byte_cnt = '0;
        nxt.phase    = (GAP_BYTES > 0) ? sdi_pkg::PH_GAP : sdi_pkg::PH_CMD;
      end
      if (fin) begin
        nxt.status = fin_code;
        nxt.phase  = sdi_pkg::PH_DONE;
      end
    end

    state_o = nxt;

    result_o                    = '0;
    result_o.done_res           = (nxt.phase == sdi_pkg::PH_DONE);
    result_o.status             = (nxt.phase == sdi_pkg::PH_DONE) ? nxt.status : sdi_pkg::ST_OK;
    result_o.last_response      = nxt.r1;
    result_o.response_timeout   = nxt.timeout;
    result_o.card_version       = nxt.version;
    result_o.card_high_capacity = nxt.capacity;
    unique case (nxt.phase)
      sdi_pkg::PH_POWER: begin
        result_o.tx_valid = 1'b1;
        result_o.tx_byte  = sdi_pkg::IDLE_BYTE;
      end
      sdi_pkg::PH_GAP, sdi_pkg::PH_POLL, sdi_pkg::PH_TAIL: begin
        result_o.tx_valid   = 1'b1;
        result_o.tx_byte    = sdi_pkg::IDLE_BYTE;
        result_o.select_low = 1'b1;
      end
      sdi_pkg::PH_CMD: begin
        result_o.tx_valid   = 1'b1;
        result_o.select_low = 1'b1;
        unique case (nxt.byte_cnt[2:0])
          3'd0:    result_o.tx_byte = nxt.frame[47:40];
          3'd1:    result_o.tx_byte = nxt.frame[39:32];
          3'd2:    result_o.tx_byte = nxt.frame[31:24];
          3'd3:    result_o.tx_byte = nxt.frame[23:16];
          3'd4:    result_o.tx_byte = nxt.frame[15:8];
          3'd5:    result_o.tx_byte = nxt.frame[7:0];
          default: result_o.tx_byte = 8'd0;
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/sd_card_spi_init_sequencer.sv]
// SD card SPI-mode initialization sequencer.
// in_i carries one item per transfer: mode 0 starts (or restarts) the
// sequence, mode 1 reports the byte received in the SPI exchange just done.
// out_o returns one result per input item: the next byte to send, whether an
// exchange is wanted, the chip-select level, and done/status/version/capacity.
// host_high_capacity_i is written when host_high_capacity_we_i is high and
// sets the HCS bit of the ACMD41 argument; write it only while idle.
// The result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the next-state logic
// and the output register form a single registered pass, so a new item is
// taken each cycle. When the receiver stalls, the result holds in the output
// register and in_i.ready drops until that result is taken.
// Reset clears the sequence to not started: results then request no
// exchange and mode 1 items are ignored until a start item arrives.
module sd_card_spi_init_sequencer #(
  parameter int POLL_LIMIT     = 256,
  parameter int OPCOND_RETRIES = 255,
  parameter int GAP_BYTES      = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      host_high_capacity_we_i,
  input  logic      host_high_capacity_i,
  sdi_in_if.sink    in_i,
  sdi_out_if.source out_o
);

  sdi_pkg::state_t  state_q, state_d;
  sdi_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             hhc_q;
  logic             in_xfer;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  sdi_step #(
    .POLL_LIMIT     (POLL_LIMIT),
    .OPCOND_RETRIES (OPCOND_RETRIES),
    .GAP_BYTES      (GAP_BYTES)
  ) u_step (
    .state_i   (state_q),
    .host_hc_i (hhc_q),
    .mode_i    (in_i.mode),
    .rx_byte_i (in_i.rx_byte),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
      hhc_q       <= 1'b0;
    end else begin
      if (host_high_capacity_we_i) begin
        hhc_q <= host_high_capacity_i;
      end
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.tx_valid           = res_q.tx_valid;
  assign out_o.tx_byte            = res_q.tx_byte;
  assign out_o.select_low         = res_q.select_low;
  assign out_o.done_res           = res_q.done_res;
  assign out_o.status             = res_q.status;
  assign out_o.last_response      = res_q.last_response;
  assign out_o.response_timeout   = res_q.response_timeout;
  assign out_o.card_version       = res_q.card_version;
  assign out_o.card_high_capacity = res_q.card_high_capacity;

endmodule

[sim/sd_card_spi_init_sequencer_test.sv]
module sd_card_spi_init_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POLL_LIMIT     = 256;
  localparam int OPCOND_RETRIES = 255;
  localparam int GAP_BYTES      = 10;
  localparam int DRAIN_CYCLES   = 4;
  localparam int QUIET_LIMIT    = 4000;

  typedef enum int {
    FLT_NONE,
    FLT_GO_IDLE,
    FLT_IF_COND,
    FLT_ECHO,
    FLT_CRC_ON,
    FLT_APP_CMD,
    FLT_OP_COND,
    FLT_READ_OCR,
    FLT_POWERUP,
    FLT_OCR_BITS,
    FLT_COUNT
  } fault_e;

  class init_scoreboard;
    bit                host_hc;
    sdi_pkg::phase_e   ph;
    logic [8:0]        cnt;
    logic [47:0]       frame;
    logic [31:0]       resp;
    logic [7:0]        retry;
    logic [1:0]        version;
    logic              cap;
    logic [3:0]        held_st;
    logic [7:0]        r1;
    logic              tmo;
    sdi_pkg::result_t  pending[$];
    int                errors;

    function new();
      host_hc = 1'b0;
      ph      = sdi_pkg::PH_IDLE;
      errors  = 0;
      clear();
    endfunction

    function void clear();
      cnt     = '0;
      frame   = '0;
      resp    = '0;
      retry   = '0;
      version = '0;
      cap     = 1'b0;
      held_st = sdi_pkg::ST_OK;
      r1      = '0;
      tmo     = 1'b0;
    endfunction

    function logic [5:0] active_cmd();
      return frame[45:40];
    endfunction

    function void open_cmd(logic [5:0] idx, logic [31:0] arg);
      logic [39:0] head;
      logic [6:0]  crc;
      logic        fb;
      head = {2'b01, idx, arg};
      crc  = '0;
      for (int i = 39; i >= 0; i--) begin
        fb  = crc[6] ^ head[i];
        crc = {crc[5:0], 1'b0};
        if (fb) begin
          crc = crc ^ 7'h09;
        end
      end
      frame = {head, crc, 1'b1};
      cnt   = '0;
      ph    = (GAP_BYTES > 0) ? sdi_pkg::PH_GAP : sdi_pkg::PH_CMD;
    endfunction

    function void conclude(logic [3:0] st);
      held_st = st;
      ph      = sdi_pkg::PH_DONE;
    endfunction

    function void take_r1();
      case (active_cmd())
        sdi_pkg::CMD_GO_IDLE: begin
          if (r1 != sdi_pkg::R1_IDLE) conclude(sdi_pkg::ST_IDLE);
          else open_cmd(sdi_pkg::CMD_IF_COND, 32'h0000_01AA);
        end
        sdi_pkg::CMD_IF_COND: begin
          ph   = sdi_pkg::PH_TAIL;
          cnt  = '0;
          resp = '0;
        end
        sdi_pkg::CMD_READ_OCR: begin
          if (r1 != 8'h00) begin
            conclude(sdi_pkg::ST_OCR);
          end else begin
            ph   = sdi_pkg::PH_TAIL;
            cnt  = '0;
            resp = '0;
          end
        end
        sdi_pkg::CMD_CRC_ON: begin
          if (r1 != sdi_pkg::R1_IDLE) conclude(sdi_pkg::ST_CRC_OFF);
          else open_cmd(sdi_pkg::CMD_APP_CMD, 32'd0);
        end
        sdi_pkg::CMD_APP_CMD: begin
          if (r1 != sdi_pkg::R1_IDLE) conclude(sdi_pkg::ST_APP_CMD);
          else open_cmd(sdi_pkg::CMD_OP_COND, host_hc ? sdi_pkg::HCS_ARG : 32'd0);
        end
        default: begin
          if (r1 > sdi_pkg::R1_IDLE) begin
            conclude(sdi_pkg::ST_OP_COND);
          end else if (r1 == sdi_pkg::R1_IDLE) begin
            if (retry >= OPCOND_RETRIES - 1) begin
              conclude(sdi_pkg::ST_OP_TIMEOUT);
            end else begin
              retry++;
              open_cmd(sdi_pkg::CMD_APP_CMD, 32'd0);
            end
          end else begin
            open_cmd(sdi_pkg::CMD_READ_OCR, 32'd0);
          end
        end
      endcase
    endfunction

    function void take_tail(logic [7:0] rx);
      logic [7:0] ocr;
      logic [8:0] win;
      resp = {resp[23:0], rx};
      cnt++;
      if (active_cmd() == sdi_pkg::CMD_IF_COND) begin
        if (cnt < 4) return;
        if (r1 == sdi_pkg::R1_ILLEGAL) begin
          version = 2'd1;
          open_cmd(sdi_pkg::CMD_CRC_ON, 32'd0);
        end else if (r1 == sdi_pkg::R1_IDLE) begin
          version = 2'd2;
          if (resp[15:8] != sdi_pkg::VHS_27_36 || resp[7:0] != sdi_pkg::CHECK_PATTERN)
            conclude(sdi_pkg::ST_UNSUPPORTED);
          else open_cmd(sdi_pkg::CMD_CRC_ON, 32'd0);
        end else begin
          conclude(sdi_pkg::ST_IF_COND);
        end
        return;
      end
      if (cnt == 1) begin
        if (!rx[7]) conclude(sdi_pkg::ST_POWERUP);
        return;
      end
      if (cnt < 3) return;
      ocr = resp[23:16];
      win = {resp[15:8], resp[7]};
      cap = ocr[6];
      if ((ocr & sdi_pkg::OCR_RSVD_MASK) != 8'h00 || win != sdi_pkg::VOLT_WINDOW)
        conclude(sdi_pkg::ST_OCR_UNSUPP);
      else conclude(sdi_pkg::ST_OK);
    endfunction

    function void note_transfer(logic mode, logic [7:0] rx);
      sdi_pkg::result_t r;
      if (!mode) begin
        clear();
        ph = sdi_pkg::PH_POWER;
      end else begin
        case (ph)
          sdi_pkg::PH_POWER: begin
            cnt++;
            if (cnt >= sdi_pkg::POWERUP_BYTES) open_cmd(sdi_pkg::CMD_GO_IDLE, 32'd0);
          end
          sdi_pkg::PH_GAP: begin
            cnt++;
            if (cnt >= GAP_BYTES) begin
              ph  = sdi_pkg::PH_CMD;
              cnt = '0;
            end
          end
          sdi_pkg::PH_CMD: begin
            cnt++;
            if (cnt >= sdi_pkg::FRAME_BYTES) begin
              ph  = sdi_pkg::PH_POLL;
              cnt = '0;
            end
          end
          sdi_pkg::PH_POLL: begin
            if (rx != sdi_pkg::IDLE_BYTE) begin
              r1  = rx;
              tmo = 1'b0;
              take_r1();
            end else begin
              cnt++;
              if (cnt >= POLL_LIMIT) begin
                r1  = sdi_pkg::IDLE_BYTE;
                tmo = 1'b1;
                take_r1();
              end
            end
          end
          sdi_pkg::PH_TAIL: take_tail(rx);
          default: ;
        endcase
      end
      r = '0;
      case (ph)
        sdi_pkg::PH_POWER: begin
          r.tx_valid = 1'b1;
          r.tx_byte  = sdi_pkg::IDLE_BYTE;
        end
        sdi_pkg::PH_GAP, sdi_pkg::PH_POLL, sdi_pkg::PH_TAIL: begin
          r.tx_valid   = 1'b1;
          r.tx_byte    = sdi_pkg::IDLE_BYTE;
          r.select_low = 1'b1;
        end
        sdi_pkg::PH_CMD: begin
          r.tx_valid   = 1'b1;
          r.select_low = 1'b1;
          r.tx_byte    = 8'(frame >> (40 - 8 * (cnt % 6)));
        end
        default: ;
      endcase
      r.done_res           = (ph == sdi_pkg::PH_DONE);
      r.status             = (ph == sdi_pkg::PH_DONE) ? held_st : sdi_pkg::ST_OK;
      r.last_response      = r1;
      r.response_timeout   = tmo;
      r.card_version       = version;
      r.card_high_capacity = cap;
      pending.push_back(r);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(sdi_pkg::result_t got);
      sdi_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp("tx_valid", want.tx_valid, got.tx_valid);
      cmp("tx_byte", want.tx_byte, got.tx_byte);
      cmp("select_low", want.select_low, got.select_low);
      cmp("done_res", want.done_res, got.done_res);
      cmp("status", want.status, got.status);
      cmp("last_response", want.last_response, got.last_response);
      cmp("response_timeout", want.response_timeout, got.response_timeout);
      cmp("card_version", want.card_version, got.card_version);
      cmp("card_high_capacity", want.card_high_capacity, got.card_high_capacity);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hc_we;
  logic hc_val;

  sdi_in_if  in_if ();
  sdi_out_if out_if ();

  sd_card_spi_init_sequencer #(
    .POLL_LIMIT     (POLL_LIMIT),
    .OPCOND_RETRIES (OPCOND_RETRIES),
    .GAP_BYTES      (GAP_BYTES)
  ) i_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .host_high_capacity_we_i (hc_we),
    .host_high_capacity_i    (hc_val),
    .in_i                    (in_if),
    .out_o                   (out_if)
  );

  init_scoreboard sb;

  int     send_idle;
  int     recv_idle;
  int     quiet;
  int     seq_no;
  bit     force_op_timeout;
  fault_e fault;
  bit     fault_timeout;
  bit     v1_card;
  int     busy_rounds;
  logic   ccs;
  int     echo_slot;
  int     ocr_break;
  int     poll_wait;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin : result_mon
    sdi_pkg::result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.tx_valid           = out_if.tx_valid;
      got.tx_byte            = out_if.tx_byte;
      got.select_low         = out_if.select_low;
      got.done_res           = out_if.done_res;
      got.status             = out_if.status;
      got.last_response      = out_if.last_response;
      got.response_timeout   = out_if.response_timeout;
      got.card_version       = out_if.card_version;
      got.card_high_capacity = out_if.card_high_capacity;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send(input logic mode_v, input logic [7:0] rx_v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode_v;
    in_if.rx_byte <= rx_v;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
    sb.note_transfer(mode_v, rx_v);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_hc(input logic v);
    @(negedge clk_i);
    hc_we  <= 1'b1;
    hc_val <= v;
    @(negedge clk_i);
    hc_we  <= 1'b0;
    sb.host_hc = v;
  endtask

  function automatic void new_personality();
    if (seq_no < FLT_COUNT) fault = fault_e'(seq_no);
    else if ($urandom_range(1) == 0) fault = fault_e'($urandom_range(FLT_COUNT - 1, 1));
    else fault = FLT_NONE;
    fault_timeout = ($urandom_range(3) == 0);
    v1_card       = ($urandom_range(3) == 0) && (fault != FLT_ECHO);
    busy_rounds   = $urandom_range(3);
    ccs           = 1'($urandom_range(1));
    echo_slot     = $urandom_range(3, 2);
    ocr_break     = $urandom_range(2);
    if (force_op_timeout) begin
      fault            = FLT_NONE;
      busy_rounds      = 255;
      force_op_timeout = 1'b0;
    end
    seq_no++;
  endfunction

  // card side: answers the exchange the block asked for
  function automatic logic [7:0] card_byte();
    logic [5:0] c;
    logic [7:0] b;
    logic       bad;
    c = sb.active_cmd();
    b = 8'($urandom_range(255));
    case (sb.ph)
      sdi_pkg::PH_POLL: begin
        case (c)
          sdi_pkg::CMD_GO_IDLE: bad = (fault == FLT_GO_IDLE);
          sdi_pkg::CMD_IF_COND: bad = (fault == FLT_IF_COND);
          sdi_pkg::CMD_CRC_ON:  bad = (fault == FLT_CRC_ON);
          sdi_pkg::CMD_APP_CMD: bad = (fault == FLT_APP_CMD);
          sdi_pkg::CMD_OP_COND: bad = (fault == FLT_OP_COND) && (sb.retry == busy_rounds);
          default:              bad = (fault == FLT_READ_OCR);
        endcase
        if (sb.cnt == 0) begin
          if (bad && fault_timeout) poll_wait = POLL_LIMIT;
          else if ($urandom_range(7) == 0) poll_wait = $urandom_range(40, 4);
          else poll_wait = $urandom_range(3);
        end
        if (sb.cnt < poll_wait) begin
          b = sdi_pkg::IDLE_BYTE;
        end else begin
          case (c)
            sdi_pkg::CMD_GO_IDLE, sdi_pkg::CMD_CRC_ON, sdi_pkg::CMD_APP_CMD:
              b = bad ? ((b == sdi_pkg::R1_IDLE || b == sdi_pkg::IDLE_BYTE) ? 8'h00 : b)
                      : sdi_pkg::R1_IDLE;
            sdi_pkg::CMD_IF_COND:
              b = bad ? ((b == sdi_pkg::R1_IDLE || b == sdi_pkg::R1_ILLEGAL ||
                          b == sdi_pkg::IDLE_BYTE) ? 8'h7F : b)
                      : (v1_card ? sdi_pkg::R1_ILLEGAL : sdi_pkg::R1_IDLE);
            sdi_pkg::CMD_OP_COND:
              b = bad ? ((b <= sdi_pkg::R1_IDLE || b == sdi_pkg::IDLE_BYTE) ? 8'h02 : b)
                      : ((sb.retry < busy_rounds) ? sdi_pkg::R1_IDLE : 8'h00);
            default:
              b = bad ? ((b == 8'h00 || b == sdi_pkg::IDLE_BYTE) ? 8'h80 : b) : 8'h00;
          endcase
        end
      end
      sdi_pkg::PH_TAIL: begin
        if (c == sdi_pkg::CMD_IF_COND) begin
          if (sb.cnt == 2) b = sdi_pkg::VHS_27_36;
          else if (sb.cnt == 3) b = sdi_pkg::CHECK_PATTERN;
          if (fault == FLT_ECHO && sb.cnt == echo_slot) b = b ^ 8'(1 << $urandom_range(7));
        end else begin
          case (sb.cnt)
            0: begin
              if (fault == FLT_POWERUP) begin
                b = b & 8'h7F;
              end else if (fault == FLT_OCR_BITS && ocr_break == 0) begin
                b = b | 8'h80;
                if ((b & sdi_pkg::OCR_RSVD_MASK) == 8'h00) b = b | 8'h10;
              end else begin
                b = {1'b1, ccs, 6'b0} | (b & 8'h0E);
              end
            end
            1: b = (fault == FLT_OCR_BITS && ocr_break == 1) ?
                   ((b == sdi_pkg::IDLE_BYTE) ? 8'hFE : b) : sdi_pkg::IDLE_BYTE;
            default: b = (fault == FLT_OCR_BITS && ocr_break == 2) ? (b & 8'h7F) : (b | 8'h80);
          endcase
        end
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic run_random(input int target);
    int counted;
    counted = 0;
    forever begin
      if (counted >= target) break;
      if (sb.ph == sdi_pkg::PH_IDLE || sb.ph == sdi_pkg::PH_DONE) begin
        repeat ($urandom_range(2)) send(1'b1, 8'($urandom_range(255)));
        if ($urandom_range(7) == 0) wait_drained();
        new_personality();
        send(1'b0, 8'($urandom_range(255)));
      end else if (busy_rounds < 8 && $urandom_range(399) == 0) begin
        send(1'b0, 8'($urandom_range(255)));
      end else begin
        send(1'b1, card_byte());
      end
      counted++;
    end
  endtask

  initial begin
    sb = new();
    in_if.valid   = 1'b0;
    in_if.mode    = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    hc_we         = 1'b0;
    hc_val        = 1'b0;
    rst_ni        = 1'b0;
    quiet         = 0;
    seq_no        = 0;
    poll_wait     = 0;
    force_op_timeout = 1'b0;
    send_idle     = 14;
    recv_idle     = 47;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_hc(1'b1);
    // not started: ignored, then start and restart
    send(1'b1, 8'h00);
    send(1'b1, 8'hFF);
    send(1'b0, 8'h00);
    send(1'b0, 8'hFF);
    for (int k = 0; k < 13; k++) send(1'b1, (k % 2) ? 8'hFF : 8'h00);
    new_personality();
    send(1'b0, 8'h5A);
    run_random(280);

    wait_drained();
    send_idle = 47;
    recv_idle = 14;
    write_hc(1'b0);
    run_random(280);

    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    write_hc(1'b1);
    force_op_timeout = 1'b1;
    run_random(290);

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
